### rtl/lockstep_frame_event_merger_core_macros.svh
// Assertion macros for the frame event merger.
`ifndef LOCKSTEP_FRAME_EVENT_MERGER_CORE_MACROS_SVH
`define LOCKSTEP_FRAME_EVENT_MERGER_CORE_MACROS_SVH

// Assert an implication under the active-low reset.
`define LFEM_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lfem check failed");

// Assert an implication in the next cycle under the active-low reset.
`define LFEM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lfem check failed");

`endif

### rtl/lfem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfem_pkg;
    localparam int MaxPlayers    = 8;
    localparam int FrameWindow   = 16;
    localparam int EventsPerSlot = 7;
    localparam int PlayerW = 3;
    localparam int FrameW  = $clog2(FrameWindow);
    localparam int SlotW   = PlayerW + FrameW;
    localparam int NSlots  = MaxPlayers * FrameWindow;
    localparam int FillW   = 3;
    localparam int EntryW  = SlotW + FillW;
    localparam int NEntries = NSlots * 8;
    localparam int CountW  = 4;

    localparam logic [31:0] FnvBasis = 32'd2166136261;
    localparam logic [31:0] FnvMul   = 32'd16777619;

    typedef enum logic [2:0] {
        RES_ACCEPTED = 3'd0,
        RES_LATE     = 3'd1,
        RES_OVERFLOW = 3'd2,
        RES_WAITING  = 3'd3,
        RES_EVENT    = 3'd4,
        RES_DONE     = 3'd5
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_RD,
        ST_SUB_WR,
        ST_EX_CHK,
        ST_EX_RD,
        ST_EX_SLOT,
        ST_EV_RD,
        ST_EV_DATA,
        ST_HASH,
        ST_EV_OUT,
        ST_CLEAR,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] owner;
        logic [31:0] kind;
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] third;
    } event_t;

    // request to and answer from the hash unit
    typedef struct packed {
        logic        start;
        logic [31:0] seed;
    } hash_req_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] value;
    } hash_rsp_t;

    localparam logic [7:0] CfgHashSeed = 8'd0;
endpackage
`default_nettype wire

### rtl/lfem_hash.sv
`timescale 1ns / 1ps
`default_nettype none
module lfem_hash (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lfem_pkg::hash_req_t req,
    input  wire lfem_pkg::event_t  ev,
    output lfem_pkg::hash_rsp_t    rsp
);
    logic [4:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [31:0]  h_reg, h_next;
    logic [159:0] words;
    logic [7:0]   byte_sel;
    logic [31:0]  mixed;

    assign words = {ev.third, ev.second, ev.first, ev.kind, ev.owner};

    always_comb
    begin
        byte_sel = words[{step_reg, 3'b000} +: 8];
        mixed = h_reg ^ {24'd0, byte_sel};
        step_next = step_reg;
        busy_next = busy_reg;
        h_next = h_reg;
        if (req.start)
        begin
            step_next = 5'd0;
            busy_next = 1'b1;
            h_next = req.seed;
        end
        else if (busy_reg)
        begin
            // one byte per cycle
            h_next = mixed * lfem_pkg::FnvMul;
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd19)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.value = h_reg;
endmodule
`default_nettype wire

### rtl/lfem_store.sv
`timescale 1ns / 1ps
`default_nettype none
module lfem_store (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [lfem_pkg::EntryW-1:0]   waddr,
    input  wire lfem_pkg::event_t              wdata,
    input  wire logic [lfem_pkg::EntryW-1:0]   raddr,
    output lfem_pkg::event_t                   rdata
);
    lfem_pkg::event_t mem [lfem_pkg::NEntries];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/lockstep_frame_event_merger_core.sv
// Lockstep frame event merger. Submits (cmd 0) store an event in a per player
// and frame slot: a slot status memory read, write back, then the result item;
// late or out of window submits go straight to the result item. Executes (cmd 1)
// check each player's slot, then walk the stored events in player and submission
// order; the hash unit folds the 20 bytes of each event at one multiply each.
// A done item with the frame and hash follows. A stalled result item holds the
// walk. Slot status is cleared by the walk; no clearing pass after reset, status
// entries have valid bits.
`timescale 1ns / 1ps
`default_nettype none
module lockstep_frame_event_merger_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [2:0]  player,
    input  wire logic [31:0] target_frame,
    input  wire logic        has_event,
    input  wire logic [31:0] event_owner,
    input  wire logic [31:0] event_kind,
    input  wire logic signed [31:0] first_arg,
    input  wire logic signed [31:0] second_arg,
    input  wire logic signed [31:0] third_arg,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [31:0]      out_owner,
    output logic [31:0]      out_kind,
    output logic signed [31:0] out_first,
    output logic signed [31:0] out_second,
    output logic signed [31:0] out_third,
    output logic [31:0]      done_frame,
    output logic [31:0]      hash_value,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int SW = lfem_pkg::SlotW;
    localparam int FW = lfem_pkg::FrameW;

    lfem_pkg::state_t state_reg, state_next;

    logic [31:0] seed_reg, seed_next;
    logic [31:0] rhash_reg, rhash_next;
    logic [31:0] frame_reg, frame_next;
    logic [lfem_pkg::CountW-1:0] pcount_reg, pcount_next;

    // slot status memory: {present, fill}, valid bit per slot
    logic [3:0] stat_mem [lfem_pkg::NSlots];
    logic [lfem_pkg::NSlots-1:0] sval_reg, sval_next;
    logic [3:0] stat_rd_reg;
    logic [SW-1:0] stat_raddr;
    logic stat_we;
    logic [SW-1:0] stat_waddr;
    logic [3:0] stat_wdata;
    logic [3:0] stat_cur;

    // held input
    logic [2:0] pl_reg, pl_next;
    logic [FW-1:0] fr_reg, fr_next;
    logic hev_reg, hev_next;
    lfem_pkg::event_t ev_reg, ev_next;
    logic [2:0] rk_reg, rk_next;

    // walk
    logic [2:0] wp_reg, wp_next;
    logic [2:0] wi_reg, wi_next;
    logic [2:0] wn_reg, wn_next;
    logic [2:0] walk_n;
    lfem_pkg::event_t rev_reg, rev_next;

    // output register
    logic ov_reg, ov_next;
    logic [2:0] ok_reg, ok_next;
    lfem_pkg::event_t oe_reg, oe_next;
    logic [31:0] of_reg, of_next, oh_reg, oh_next;
    logic ol_reg, ol_next;

    logic mem_we;
    logic [lfem_pkg::EntryW-1:0] mem_waddr, mem_raddr;
    lfem_pkg::event_t mem_rdata;

    lfem_pkg::hash_req_t hreq;
    lfem_pkg::hash_rsp_t hrsp;

    logic cfg_wr, accept, out_free;
    logic [31:0] diff;
    logic [SW-1:0] sub_slot, walk_slot;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = seed_reg;
    assign in_stall = (state_reg != lfem_pkg::ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign diff = target_frame - frame_reg;
    assign sub_slot = {pl_reg, fr_reg};
    assign walk_slot = {wp_reg, frame_reg[FW-1:0]};
    assign stat_cur = sval_reg[stat_raddr] ? stat_rd_reg : 4'd0;
    assign walk_n = (wi_reg == 3'd0 && wn_reg == 3'd0) ? stat_cur[2:0] : wn_reg;

    lfem_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (ev_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lfem_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .ev    (rev_reg),
        .rsp   (hrsp)
    );

    always_ff @(posedge clk)
    begin
        if (stat_we)
            stat_mem[stat_waddr] <= stat_wdata;
        stat_rd_reg <= stat_mem[stat_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfem_pkg::ST_IDLE:
                if (accept)
                begin
                    if (cmd)
                        state_next = (pcount_reg == '0) ? lfem_pkg::ST_OUT
                                                        : lfem_pkg::ST_EX_RD;
                    else if (target_frame < frame_reg || diff >= 32'(lfem_pkg::FrameWindow))
                        state_next = lfem_pkg::ST_OUT;
                    else
                        state_next = lfem_pkg::ST_SUB_RD;
                end
            lfem_pkg::ST_SUB_RD:  state_next = lfem_pkg::ST_SUB_WR;
            lfem_pkg::ST_SUB_WR:  state_next = lfem_pkg::ST_OUT;
            lfem_pkg::ST_EX_RD:   state_next = lfem_pkg::ST_EX_CHK;
            lfem_pkg::ST_EX_CHK:
                if (!stat_cur[3])
                    state_next = lfem_pkg::ST_OUT;
                else if ({1'b0, wp_reg} + 4'd1 == pcount_reg)
                    state_next = lfem_pkg::ST_EX_SLOT;
                else
                    state_next = lfem_pkg::ST_EX_RD;
            lfem_pkg::ST_EX_SLOT:
                state_next = lfem_pkg::ST_CLEAR;
            lfem_pkg::ST_CLEAR:
                if (wi_reg < walk_n)
                    state_next = lfem_pkg::ST_EV_RD;
                else if ({1'b0, wp_reg} + 4'd1 >= pcount_reg)
                    state_next = lfem_pkg::ST_DONE;
                else
                    state_next = lfem_pkg::ST_EX_SLOT;
            lfem_pkg::ST_EV_RD:   state_next = lfem_pkg::ST_EV_DATA;
            lfem_pkg::ST_EV_DATA: state_next = lfem_pkg::ST_HASH;
            lfem_pkg::ST_HASH:
                if (!hrsp.busy)
                    state_next = lfem_pkg::ST_EV_OUT;
            lfem_pkg::ST_EV_OUT:
                if (out_free)
                    state_next = lfem_pkg::ST_CLEAR;
            lfem_pkg::ST_DONE:
                if (out_free)
                    state_next = lfem_pkg::ST_IDLE;
            lfem_pkg::ST_OUT:
                if (out_free)
                    state_next = lfem_pkg::ST_IDLE;
            default: state_next = lfem_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        seed_next = seed_reg;
        rhash_next = rhash_reg;
        frame_next = frame_reg;
        pcount_next = pcount_reg;
        sval_next = sval_reg;
        pl_next = pl_reg;
        fr_next = fr_reg;
        hev_next = hev_reg;
        ev_next = ev_reg;
        rk_next = rk_reg;
        wp_next = wp_reg;
        wi_next = wi_reg;
        wn_next = wn_reg;
        rev_next = rev_reg;
        ov_next = ov_reg;
        ok_next = ok_reg;
        oe_next = oe_reg;
        of_next = of_reg;
        oh_next = oh_reg;
        ol_next = ol_reg;
        stat_raddr = sub_slot;
        stat_we = 1'b0;
        stat_waddr = sub_slot;
        stat_wdata = 4'd0;
        mem_we = 1'b0;
        mem_waddr = {sub_slot, stat_cur[2:0]};
        mem_raddr = {walk_slot, wi_reg};
        hreq.start = 1'b0;
        hreq.seed = rhash_reg;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        if (cfg_wr && paddr == lfem_pkg::CfgHashSeed[0])
        begin
            seed_next = pwdata;
            rhash_next = pwdata;
        end

        unique case (state_reg)
            lfem_pkg::ST_IDLE:
                if (accept)
                begin
                    pl_next = player;
                    fr_next = target_frame[FW-1:0];
                    hev_next = has_event;
                    ev_next = '{event_owner, event_kind, first_arg, second_arg, third_arg};
                    wp_next = '0;
                    if (cmd)
                        rk_next = lfem_pkg::RES_WAITING;
                    else
                    begin
                        if (pcount_reg < {1'b0, player} + 4'd1)
                            pcount_next = {1'b0, player} + 4'd1;
                        if (target_frame < frame_reg)
                            rk_next = lfem_pkg::RES_LATE;
                        else
                            rk_next = lfem_pkg::RES_OVERFLOW;
                    end
                end
            lfem_pkg::ST_SUB_WR:
            begin
                stat_we = 1'b1;
                sval_next[sub_slot] = 1'b1;
                if (hev_reg && stat_cur[2:0] >= 3'(lfem_pkg::EventsPerSlot))
                begin
                    stat_wdata = {1'b1, stat_cur[2:0]};
                    rk_next = lfem_pkg::RES_OVERFLOW;
                end
                else if (hev_reg)
                begin
                    stat_wdata = {1'b1, stat_cur[2:0] + 3'd1};
                    mem_we = 1'b1;
                    rk_next = lfem_pkg::RES_ACCEPTED;
                end
                else
                begin
                    stat_wdata = {1'b1, stat_cur[2:0]};
                    rk_next = lfem_pkg::RES_ACCEPTED;
                end
            end
            lfem_pkg::ST_EX_RD:
                stat_raddr = walk_slot;
            lfem_pkg::ST_EX_CHK:
            begin
                stat_raddr = walk_slot;
                if (stat_cur[3] && ({1'b0, wp_reg} + 4'd1 != pcount_reg))
                    wp_next = wp_reg + 3'd1;
                else if (stat_cur[3])
                    wp_next = '0;
            end
            lfem_pkg::ST_EX_SLOT:
                stat_raddr = walk_slot;
            lfem_pkg::ST_CLEAR:
            begin
                stat_raddr = walk_slot;
                wn_next = walk_n;
                if (wi_reg >= walk_n)
                begin
                    // drop the slot and advance the player
                    sval_next[walk_slot] = 1'b0;
                    wi_next = '0;
                    wn_next = '0;
                    wp_next = wp_reg + 3'd1;
                end
            end
            lfem_pkg::ST_EV_DATA:
            begin
                stat_raddr = walk_slot;
                rev_next = mem_rdata;
                hreq.start = 1'b1;
            end
            lfem_pkg::ST_HASH:
                stat_raddr = walk_slot;
            lfem_pkg::ST_EV_OUT:
            begin
                stat_raddr = walk_slot;
                if (out_free)
                begin
                    rhash_next = hrsp.value;
                    ov_next = 1'b1;
                    ok_next = lfem_pkg::RES_EVENT;
                    oe_next = rev_reg;
                    of_next = '0;
                    oh_next = '0;
                    ol_next = 1'b0;
                    wi_next = wi_reg + 3'd1;
                end
            end
            lfem_pkg::ST_DONE:
                if (out_free)
                begin
                    // clear this frame's slot of every player
                    for (int q = 0; q < lfem_pkg::MaxPlayers; q++)
                        sval_next[{3'(q), frame_reg[FW-1:0]}] = 1'b0;
                    ov_next = 1'b1;
                    ok_next = lfem_pkg::RES_DONE;
                    oe_next = '0;
                    of_next = frame_reg;
                    oh_next = rhash_reg;
                    ol_next = 1'b1;
                    frame_next = frame_reg + 32'd1;
                    wp_next = '0;
                end
            lfem_pkg::ST_OUT:
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ok_next = rk_reg;
                    oe_next = '0;
                    of_next = '0;
                    oh_next = '0;
                    ol_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfem_pkg::ST_IDLE;
            seed_reg <= lfem_pkg::FnvBasis;
            rhash_reg <= lfem_pkg::FnvBasis;
            frame_reg <= '0;
            pcount_reg <= '0;
            sval_reg <= '0;
            ov_reg <= 1'b0;
            wp_reg <= '0;
            wi_reg <= '0;
            wn_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg <= seed_next;
            rhash_reg <= rhash_next;
            frame_reg <= frame_next;
            pcount_reg <= pcount_next;
            sval_reg <= sval_next;
            ov_reg <= ov_next;
            wp_reg <= wp_next;
            wi_reg <= wi_next;
            wn_reg <= wn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg <= pl_next;
        fr_reg <= fr_next;
        hev_reg <= hev_next;
        ev_reg <= ev_next;
        rk_reg <= rk_next;
        rev_reg <= rev_next;
        ok_reg <= ok_next;
        oe_reg <= oe_next;
        of_reg <= of_next;
        oh_reg <= oh_next;
        ol_reg <= ol_next;
    end

    assign out_valid = ov_reg;
    assign kind = ok_reg;
    assign out_owner = oe_reg.owner;
    assign out_kind = oe_reg.kind;
    assign out_first = oe_reg.first;
    assign out_second = oe_reg.second;
    assign out_third = oe_reg.third;
    assign done_frame = of_reg;
    assign hash_value = oh_reg;
    assign last = ol_reg;
endmodule
`default_nettype wire

### rtl/lfem_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lockstep_frame_event_merger_core_macros.svh"
module lfem_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  kind,
    input wire logic        last,
    input wire logic [31:0] out_owner
);
    logic is_event;

    assign is_event = (kind == lfem_pkg::RES_EVENT);

    `LFEM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kind))
    `LFEM_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, kind <= lfem_pkg::RES_DONE)
    `LFEM_ASSERT_IMPL(a_event_not_last, clk, rst_n, out_valid && is_event, !last)
    `LFEM_ASSERT_IMPL(a_other_last, clk, rst_n, out_valid && !is_event, last && out_owner == 32'd0)
    `LFEM_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind lockstep_frame_event_merger_core lfem_checker u_lfem_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .last      (last),
    .out_owner (out_owner)
);
`default_nettype wire

### tb/tb_lockstep_frame_event_merger_core.sv
`timescale 1ns / 1ps
module tb_lockstep_frame_event_merger_core;
    localparam int StallLimit = 20000;
    localparam int Players = 8;
    localparam int Window = 16;
    localparam int Depth = 7;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  player;
        logic [31:0] frame;
        logic        has_ev;
        lfem_pkg::event_t ev;
    } cmd_item_t;

    typedef struct packed {
        lfem_pkg::res_kind_t kind;
        lfem_pkg::event_t    ev;
        logic [31:0] frame;
        logic [31:0] hash;
        logic        last;
    } merge_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = 1'b0;
    logic [2:0] player = '0;
    logic [31:0] target_frame = '0;
    logic has_event = 1'b0;
    logic [31:0] event_owner = '0;
    logic [31:0] event_kind = '0;
    logic signed [31:0] first_arg = '0;
    logic signed [31:0] second_arg = '0;
    logic signed [31:0] third_arg = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] kind;
    logic [31:0] out_owner, out_kind, done_frame, hash_value;
    logic signed [31:0] out_first, out_second, out_third;
    logic last;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lockstep_frame_event_merger_core uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [3:0]  seen_players;
    logic [31:0] cur_frame;
    logic [31:0] run_hash;
    logic        handed_in [Players*Window];
    int          fill_level [Players*Window];
    lfem_pkg::event_t stored_ev [Players*Window][Depth];
    merge_res_t  pending_results [$];
    int          send_idle_pct, recv_idle_pct;
    int          quiet_cycles;
    bit          failed;

    function automatic logic [31:0] fnv_word(logic [31:0] h, logic [31:0] w);
        for (int b = 0; b < 4; b++)
            h = (h ^ {24'd0, w[8*b +: 8]}) * lfem_pkg::FnvMul;
        return h;
    endfunction

    function automatic merge_res_t plain_res(lfem_pkg::res_kind_t k, logic lst);
        merge_res_t r;
        r = '0;
        r.kind = k;
        r.last = lst;
        return r;
    endfunction

    task automatic queue_result(merge_res_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic predict_merge(cmd_item_t it);
        int slot;
        int s;
        merge_res_t r;
        logic ready;
        if (!it.cmd)
        begin
            if (seen_players < {1'b0, it.player} + 4'd1)
                seen_players = {1'b0, it.player} + 4'd1;
            if (it.frame < cur_frame)
                queue_result(plain_res(lfem_pkg::RES_LATE, 1'b1));
            else if (it.frame - cur_frame >= Window)
                queue_result(plain_res(lfem_pkg::RES_OVERFLOW, 1'b1));
            else
            begin
                slot = it.player * Window + it.frame % Window;
                handed_in[slot] = 1'b1;
                if (it.has_ev && fill_level[slot] >= Depth)
                    queue_result(plain_res(lfem_pkg::RES_OVERFLOW, 1'b1));
                else
                begin
                    if (it.has_ev)
                    begin
                        stored_ev[slot][fill_level[slot]] = it.ev;
                        fill_level[slot]++;
                    end
                    queue_result(plain_res(lfem_pkg::RES_ACCEPTED, 1'b1));
                end
            end
            return;
        end
        ready = seen_players != 0;
        for (int p = 0; p < seen_players; p++)
            if (!handed_in[p * Window + cur_frame % Window]) ready = 1'b0;
        if (!ready)
        begin
            queue_result(plain_res(lfem_pkg::RES_WAITING, 1'b1));
            return;
        end
        for (int p = 0; p < Players; p++)
        begin
            s = p * Window + cur_frame % Window;
            if (p < seen_players)
                for (int i = 0; i < fill_level[s]; i++)
                begin
                    run_hash = fnv_word(run_hash, stored_ev[s][i].owner);
                    run_hash = fnv_word(run_hash, stored_ev[s][i].kind);
                    run_hash = fnv_word(run_hash, stored_ev[s][i].first);
                    run_hash = fnv_word(run_hash, stored_ev[s][i].second);
                    run_hash = fnv_word(run_hash, stored_ev[s][i].third);
                    r = plain_res(lfem_pkg::RES_EVENT, 1'b0);
                    r.ev = stored_ev[s][i];
                    queue_result(r);
                end
            handed_in[s] = 1'b0;
            fill_level[s] = 0;
        end
        r = plain_res(lfem_pkg::RES_DONE, 1'b1);
        r.frame = cur_frame;
        r.hash = run_hash;
        queue_result(r);
        cur_frame++;
    endtask

    task automatic send_item(cmd_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= it.cmd;
        player <= it.player;
        target_frame <= it.frame;
        has_event <= it.has_ev;
        event_owner <= it.ev.owner;
        event_kind <= it.ev.kind;
        first_arg <= it.ev.first;
        second_arg <= it.ev.second;
        third_arg <= it.ev.third;
        do
            @(posedge clk);
        while (in_stall);
        predict_merge(it);
    endtask

    task automatic write_seed(logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= lfem_pkg::CfgHashSeed[0];
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        run_hash = v;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic lfem_pkg::event_t rand_event();
        lfem_pkg::event_t e;
        e.owner = $urandom;
        e.kind = $urandom;
        e.first = $urandom;
        e.second = $urandom;
        e.third = $urandom;
        return e;
    endfunction

    function automatic cmd_item_t submit(int p, logic [31:0] f, logic h);
        cmd_item_t it;
        it.cmd = 1'b0;
        it.player = 3'(p);
        it.frame = f;
        it.has_ev = h;
        it.ev = rand_event();
        return it;
    endfunction

    function automatic cmd_item_t execute();
        cmd_item_t it;
        it = submit($urandom_range(7), $urandom, 1'($urandom_range(1)));
        it.cmd = 1'b1;
        return it;
    endfunction

    task automatic test_directed;
        lfem_pkg::event_t e;
        cmd_item_t it;
        send_item(execute());
        it = submit(0, 0, 1'b1);
        it.ev = '1;
        send_item(it);
        it.ev = '0;
        send_item(it);
        e = '0;
        e.first = 32'h8000_0000;
        e.second = 32'h7fff_ffff;
        e.third = 32'hffff_ffff;
        it.ev = e;
        send_item(it);
        for (int i = 0; i < 5; i++) send_item(submit(0, 0, 1'b1));
        send_item(submit(0, 15, 1'b0));
        send_item(submit(0, 16, 1'b1));
        send_item(submit(0, 32'hffff_ffff, 1'b1));
        send_item(submit(2, 0, 1'b1));
        send_item(execute());
        send_item(submit(1, 0, 1'b0));
        send_item(execute());
        send_item(submit(0, 0, 1'b1));
        send_item(execute());
        send_item(submit(7, 1, 1'b1));
        send_item(execute());
        drain();
    endtask

    task automatic test_frame_wrap;
        cmd_item_t it;
        write_seed(32'hffff_ffff);
        for (int f = 0; f < 3; f++)
        begin
            for (int p = 0; p < Players; p++)
                send_item(submit(p, cur_frame, 1'b1));
            send_item(execute());
        end
        drain();
        write_seed(32'd0);
        it = submit(3, cur_frame, 1'b1);
        send_item(it);
        drain();
    endtask

    task automatic test_random(int n);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) < 7)
            begin
                for (int p = 0; p < seen_players && p < Players; p++)
                begin
                    repeat ($urandom_range(3))
                    begin
                        send_item(submit(p, cur_frame + $urandom_range(2),
                                         $urandom_range(3) != 0));
                        sent++;
                    end
                    send_item(submit(p, cur_frame, 1'($urandom_range(1))));
                    sent++;
                end
                send_item(execute());
                sent++;
            end
            else
            begin
                case ($urandom_range(3))
                    0: send_item(submit($urandom_range(7), cur_frame - $urandom_range(1, 5),
                                        1'b1));
                    1: send_item(submit($urandom_range(7),
                                        cur_frame + $urandom_range(16, 40), 1'b1));
                    2: send_item(submit($urandom_range(7), $urandom,
                                        1'($urandom_range(1))));
                    default: send_item(execute());
                endcase
                sent++;
            end
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        merge_res_t exp_r, got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '0;
            got.kind = lfem_pkg::res_kind_t'(kind);
            got.ev = {out_owner, out_kind, out_first, out_second, out_third};
            got.frame = done_frame;
            got.hash = hash_value;
            got.last = last;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result, expected none, actual %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    $display("%0t result differs: expected kind %0d ev %h frame %h hash %h last %b",
                             $time, exp_r.kind, exp_r.ev, exp_r.frame, exp_r.hash, exp_r.last);
                    $display("%0t                 actual   kind %0d ev %h frame %h hash %h last %b",
                             $time, got.kind, got.ev, got.frame, got.hash, got.last);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        failed = 1'b0;
        quiet_cycles = 0;
        seen_players = '0;
        cur_frame = '0;
        run_hash = lfem_pkg::FnvBasis;
        for (int s = 0; s < Players*Window; s++)
        begin
            handed_in[s] = 1'b0;
            fill_level[s] = 0;
        end
        send_idle_pct = 11;
        recv_idle_pct = 48;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_frame_wrap();
        test_random(55);
        send_idle_pct = 48;
        recv_idle_pct = 11;
        write_seed($urandom);
        test_random(55);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed(lfem_pkg::FnvBasis);
        test_random(55);
        if (!failed)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/lfem_pkg.sv
rtl/lfem_hash.sv
rtl/lfem_store.sv
rtl/lockstep_frame_event_merger_core.sv
rtl/lfem_checker.sv
tb/tb_lockstep_frame_event_merger_core.sv
